FILE: rtl/core/tcl_pkg.sv
// ============================================================================
// Thermistor channel linearizer package
// Shared constants, status codes, register indexes and the code ROM of the
// thermistor linearizer.
// ============================================================================
package tcl_pkg;

    // Number of table entries used by the search, and the stored ROM size.
    localparam int TABLE_ENTRIES = 154;
    localparam int ROM_SIZE      = 154;
    localparam int IDX_W         = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ROM_ADDR_W    = 8;

    localparam int CODE_W   = 10;
    localparam int ROM_W    = 9;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int FAHR_W   = 8;
    localparam int CELS_W   = 7;
    localparam int NUM_W    = 12;
    localparam int PROD_W   = 24;

    localparam logic [FAHR_W:0]   F_OFFSET    = 9'd5;
    localparam logic [FAHR_W-1:0] F_FREEZE    = 8'd32;
    localparam logic [FAHR_W-1:0] F_RESET     = 8'd36;
    localparam logic [FAHR_W-1:0] F_MAX       = 8'd255;
    localparam logic [7:0]        C_OFFSET    = 8'd15;
    localparam logic [8:0]        C_MAX       = 9'd127;
    localparam logic [NUM_W-1:0]  ROUND_BIAS  = 12'd9;
    // Division by 18 as a multiply by 3641 / 2^16, exact for numerators below 4096.
    localparam logic [NUM_W-1:0]  RECIP_18    = 12'd3641;
    localparam int                RECIP_SHIFT = 16;

    // Sensor status codes.
    localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OPEN   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd3;

    // Configuration register indexes and reset values.
    localparam int                 PADDR_W           = 4;
    localparam logic [1:0]         REG_OPEN_LIMIT    = 2'd0;
    localparam logic [1:0]         REG_SHORT_LIMIT   = 2'd1;
    localparam logic [1:0]         REG_CONFIRM_COUNT = 2'd2;
    localparam logic [CODE_W-1:0]  OPEN_LIMIT_RST    = 10'd30;
    localparam logic [CODE_W-1:0]  SHORT_LIMIT_RST   = 10'd500;
    localparam logic [COUNT_W-1:0] CONFIRM_RST       = 4'd2;

    localparam logic [ROM_W-1:0] CODE_ROM [0:ROM_SIZE-1] = '{
        9'd75,  9'd77,  9'd79,  9'd81,  9'd83,  9'd85,  9'd86,  9'd88,  9'd90,  9'd93,
        9'd95,  9'd97,  9'd99,  9'd101, 9'd103, 9'd105, 9'd108, 9'd110, 9'd112, 9'd114,
        9'd117, 9'd119, 9'd121, 9'd124, 9'd126, 9'd128, 9'd131, 9'd133, 9'd136, 9'd138,
        9'd141, 9'd143, 9'd146, 9'd149, 9'd151, 9'd154, 9'd156, 9'd159, 9'd162, 9'd164,
        9'd167, 9'd170, 9'd173, 9'd175, 9'd178, 9'd181, 9'd184, 9'd186, 9'd189, 9'd192,
        9'd195, 9'd197, 9'd200, 9'd203, 9'd206, 9'd209, 9'd211, 9'd214, 9'd217, 9'd220,
        9'd223, 9'd225, 9'd228, 9'd231, 9'd234, 9'd237, 9'd239, 9'd242, 9'd245, 9'd248,
        9'd251, 9'd253, 9'd256, 9'd259, 9'd261, 9'd264, 9'd267, 9'd270, 9'd272, 9'd275,
        9'd278, 9'd280, 9'd283, 9'd285, 9'd288, 9'd291, 9'd293, 9'd296, 9'd298, 9'd301,
        9'd303, 9'd306, 9'd308, 9'd311, 9'd313, 9'd316, 9'd318, 9'd320, 9'd323, 9'd325,
        9'd327, 9'd330, 9'd332, 9'd334, 9'd336, 9'd339, 9'd341, 9'd343, 9'd345, 9'd347,
        9'd349, 9'd351, 9'd353, 9'd356, 9'd358, 9'd360, 9'd362, 9'd364, 9'd365, 9'd367,
        9'd369, 9'd371, 9'd373, 9'd375, 9'd377, 9'd379, 9'd380, 9'd382, 9'd384, 9'd385,
        9'd387, 9'd389, 9'd390, 9'd392, 9'd394, 9'd395, 9'd397, 9'd398, 9'd400, 9'd401,
        9'd403, 9'd404, 9'd406, 9'd407, 9'd409, 9'd410, 9'd412, 9'd413, 9'd415, 9'd416,
        9'd417, 9'd418, 9'd419, 9'd421
    };

    // Positions past the stored entries read as the last entry.
    function automatic logic [ROM_W-1:0] rom_read(input logic [ROM_ADDR_W-1:0] addr);
        logic [ROM_W-1:0] val;
        if (int'(addr) >= ROM_SIZE) begin
            val = CODE_ROM[ROM_SIZE-1];
        end else begin
            val = CODE_ROM[addr];
        end
        return val;
    endfunction

endpackage

FILE: rtl/core/thermistor_channel_linearizer.sv
// ============================================================================
// Thermistor channel linearizer
// Open/short detection and table linearisation of one thermistor channel.
// ============================================================================
// Usage:
// Samples arrive on the input channel (in_valid / in_ready, adc_code and
// startup_hold); one result leaves on the output channel (out_valid /
// out_ready, sensor_status, temp_fahrenheit, temp_celsius_offset) for every
// input transfer. The user must write the limits and the confirm count over
// the APB port only while the block is idle; the block does not enforce it.
// pready is always high and reads return the value. A fault sample goes
// straight to the output step, which registers its result once the output
// register is free, and the block then returns to idle for the next sample.
// A normal sample runs a binary search over the code ROM through one shared
// subtract/compare unit: two end probes, up to IDX_W search probes and one
// closing step, up to two neighbour probes, then a Fahrenheit step, a
// Celsius step with one multiply and the output step. A code at or beyond a
// table end skips the search and the neighbour probes. in_ready is low until
// the block returns to idle.
// The result waits in an output register; the next sample is taken while it
// waits, and only its own result stalls until the receiver takes the first.
// Reset clears the fault counter, sets the status to normal, Fahrenheit to
// 36, Celsius to 0 and the registers to their default values.
// ============================================================================
module thermistor_channel_linearizer
    import tcl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CODE_W-1:0]     adc_code,
    input  logic                  startup_hold,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   sensor_status,
    output logic [FAHR_W-1:0]     temp_fahrenheit,
    output logic [CELS_W-1:0]     temp_celsius_offset,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_LOW_END  = 9'b000000010,
        ST_HIGH_END = 9'b000000100,
        ST_SEARCH   = 9'b000001000,
        ST_PICK_HI  = 9'b000010000,
        ST_PICK_LO  = 9'b000100000,
        ST_CONV     = 9'b001000000,
        ST_CELS     = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

    state_t               state_reg, state_next;
    logic [CODE_W-1:0]    open_limit_reg, open_limit_next;
    logic [CODE_W-1:0]    short_limit_reg, short_limit_next;
    logic [COUNT_W-1:0]   confirm_reg, confirm_next;
    logic [COUNT_W-1:0]   fault_count_reg, fault_count_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [FAHR_W-1:0]    fahrenheit_reg, fahrenheit_next;
    logic [CELS_W-1:0]    celsius_reg, celsius_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CODE_W-1:0]    code_reg, code_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]     hi_reg, hi_next;
    logic [CODE_W-1:0]    x_reg, x_next;
    logic [FAHR_W-1:0]    fcalc_reg, fcalc_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic                 below_reg, below_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [FAHR_W-1:0]    out_fahr_reg, out_fahr_next;
    logic [CELS_W-1:0]    out_cels_reg, out_cels_next;

    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic                 in_fire;
    logic [STATUS_W-1:0]  kind;
    logic [COUNT_W-1:0]   count_inc;
    logic [IDX_W:0]       mid_sum;
    logic [IDX_W-1:0]     mid;
    logic [IDX_W-1:0]     probe_idx;
    logic [ROM_W-1:0]     rom_val;
    logic [CODE_W:0]      diff;
    logic [CODE_W-1:0]    neg_diff;
    logic                 rom_ge;
    logic                 rom_eq;
    logic [FAHR_W:0]      f_sum;
    logic [FAHR_W-1:0]    f_sat;
    logic                 f_below;
    logic [FAHR_W-1:0]    f_dist;
    logic [PROD_W-1:0]    prod;
    logic [7:0]           quot;
    logic [8:0]           cels_wide;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        case (cfg_index)
            REG_OPEN_LIMIT:    prdata = 32'(open_limit_reg);
            REG_SHORT_LIMIT:   prdata = 32'(short_limit_reg);
            REG_CONFIRM_COUNT: prdata = 32'(confirm_reg);
            default:           prdata = 32'd0;
        endcase
    end

    // Shared subtract/compare unit against one ROM entry.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IDX_W:1];

    always_comb
    begin
        case (state_reg)
            ST_LOW_END:  probe_idx = '0;
            ST_HIGH_END: probe_idx = LAST_IDX;
            ST_SEARCH:   probe_idx = mid;
            ST_PICK_HI:  probe_idx = lo_reg;
            ST_PICK_LO:  probe_idx = lo_reg - ONE_IDX;
            default:     probe_idx = '0;
        endcase
    end

    assign rom_val  = rom_read(ROM_ADDR_W'(probe_idx));
    assign diff     = {2'b00, rom_val} - {1'b0, code_reg};
    assign neg_diff = code_reg - {1'b0, rom_val};
    assign rom_ge   = !diff[CODE_W];
    assign rom_eq   = (diff == '0);

    // Fault classification of the incoming sample; open wins over short.
    always_comb
    begin
        if (!startup_hold && (adc_code < open_limit_reg)) begin
            kind = STATUS_OPEN;
        end else if (!startup_hold && (adc_code > short_limit_reg)) begin
            kind = STATUS_SHORT;
        end else begin
            kind = STATUS_NORMAL;
        end
    end

    assign count_inc = fault_count_reg + 4'd1;

    // Fahrenheit from the found index, and the numerator for the Celsius step.
    assign f_sum   = 9'(lo_reg) + F_OFFSET;
    assign f_sat   = (f_sum > {1'b0, F_MAX}) ? F_MAX : f_sum[FAHR_W-1:0];
    assign f_below = (f_sat <= F_FREEZE);
    assign f_dist  = f_below ? (F_FREEZE - f_sat) : (f_sat - F_FREEZE);

    assign prod = PROD_W'(num_reg) * PROD_W'(RECIP_18);
    assign quot = prod[RECIP_SHIFT +: 8];

    always_comb
    begin
        if (below_reg) begin
            cels_wide = (quot >= C_OFFSET) ? 9'd0 : 9'(C_OFFSET - quot);
        end else begin
            cels_wide = 9'(quot) + 9'(C_OFFSET);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        open_limit_next  = open_limit_reg;
        short_limit_next = short_limit_reg;
        confirm_next     = confirm_reg;
        fault_count_next = fault_count_reg;
        status_next      = status_reg;
        fahrenheit_next  = fahrenheit_reg;
        celsius_next     = celsius_reg;
        out_valid_next   = out_valid_reg;
        code_next        = code_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        x_next           = x_reg;
        fcalc_next       = fcalc_reg;
        num_next         = num_reg;
        below_next       = below_reg;
        out_status_next  = out_status_reg;
        out_fahr_next    = out_fahr_reg;
        out_cels_next    = out_cels_reg;

        if (cfg_write) begin
            case (cfg_index)
                REG_OPEN_LIMIT:    open_limit_next  = pwdata[CODE_W-1:0];
                REG_SHORT_LIMIT:   short_limit_next = pwdata[CODE_W-1:0];
                REG_CONFIRM_COUNT: confirm_next     = pwdata[COUNT_W-1:0];
                default:           ;
            endcase
        end

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    code_next = adc_code;
                    if (kind != STATUS_NORMAL) begin
                        if (count_inc >= confirm_reg) begin
                            fault_count_next = '0;
                            status_next      = kind;
                            fahrenheit_next  = '0;
                        end else begin
                            fault_count_next = count_inc;
                        end
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_LOW_END;
                    end
                end
            end
            ST_LOW_END:
            begin
                if (rom_ge) begin
                    lo_next    = '0;
                    state_next = ST_CONV;
                end else begin
                    state_next = ST_HIGH_END;
                end
            end
            ST_HIGH_END:
            begin
                if (diff[CODE_W] || rom_eq) begin
                    lo_next    = LAST_IDX;
                    state_next = ST_CONV;
                end else begin
                    lo_next    = ONE_IDX;
                    hi_next    = LAST_IDX;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                // Finds the smallest index whose entry is not below the code.
                if (lo_reg == hi_reg) begin
                    state_next = ST_PICK_HI;
                end else if (rom_ge) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid + ONE_IDX;
                end
            end
            ST_PICK_HI:
            begin
                if (rom_eq) begin
                    state_next = ST_CONV;
                end else begin
                    x_next     = diff[CODE_W-1:0];
                    state_next = ST_PICK_LO;
                end
            end
            ST_PICK_LO:
            begin
                // A tie between the neighbours goes to the higher index.
                if (x_reg > neg_diff) begin
                    lo_next = lo_reg - ONE_IDX;
                end
                state_next = ST_CONV;
            end
            ST_CONV:
            begin
                fcalc_next = f_sat;
                below_next = f_below;
                num_next   = {1'b0, f_dist, 3'b000} + {3'b000, f_dist, 1'b0} + ROUND_BIAS;
                state_next = ST_CELS;
            end
            ST_CELS:
            begin
                fault_count_next = '0;
                status_next      = STATUS_NORMAL;
                fahrenheit_next  = fcalc_reg;
                celsius_next     = (cels_wide > C_MAX) ? C_MAX[CELS_W-1:0]
                                                       : cels_wide[CELS_W-1:0];
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_fahr_next   = fahrenheit_reg;
                    out_cels_next   = celsius_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            open_limit_reg  <= OPEN_LIMIT_RST;
            short_limit_reg <= SHORT_LIMIT_RST;
            confirm_reg     <= CONFIRM_RST;
            fault_count_reg <= '0;
            status_reg      <= STATUS_NORMAL;
            fahrenheit_reg  <= F_RESET;
            celsius_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            open_limit_reg  <= open_limit_next;
            short_limit_reg <= short_limit_next;
            confirm_reg     <= confirm_next;
            fault_count_reg <= fault_count_next;
            status_reg      <= status_next;
            fahrenheit_reg  <= fahrenheit_next;
            celsius_reg     <= celsius_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        x_reg          <= x_next;
        fcalc_reg      <= fcalc_next;
        num_reg        <= num_next;
        below_reg      <= below_next;
        out_status_reg <= out_status_next;
        out_fahr_reg   <= out_fahr_next;
        out_cels_reg   <= out_cels_next;
    end

    assign out_valid           = out_valid_reg;
    assign sensor_status       = out_status_reg;
    assign temp_fahrenheit     = out_fahr_reg;
    assign temp_celsius_offset = out_cels_reg;

endmodule

FILE: rtl/core/tcl_checker.sv
// ============================================================================
// Thermistor channel linearizer checker
// Port-level assertions on the result channel and the sample handshake.
// ============================================================================
module tcl_checker
    import tcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [STATUS_W-1:0]  sensor_status,
    input  logic [FAHR_W-1:0]    temp_fahrenheit,
    input  logic [CELS_W-1:0]    temp_celsius_offset
);

    // A stalled result keeps its payload until the transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sensor_status)
            && $stable(temp_fahrenheit) && $stable(temp_celsius_offset))
        else $error("result changed while stalled");

    // Once a sample is taken, in_ready drops while the block is busy with it.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while busy");

    // A confirmed fault always reports a zero Fahrenheit reading.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sensor_status == STATUS_OPEN || sensor_status == STATUS_SHORT)
            |-> temp_fahrenheit == '0)
        else $error("fault result with nonzero temperature");

    // A normal status never carries a zero reading, and no undefined code appears.
    a_normal_reading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sensor_status != STATUS_BAD
            && (sensor_status != STATUS_NORMAL || temp_fahrenheit != '0))
        else $error("inconsistent status and temperature");

endmodule

bind thermistor_channel_linearizer tcl_checker u_tcl_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .sensor_status       (sensor_status),
    .temp_fahrenheit     (temp_fahrenheit),
    .temp_celsius_offset (temp_celsius_offset)
);

FILE: tb/tcl_checker_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// Thermistor linearizer reading checker
// Predicts the status and temperatures of the linearizer for every accepted
// sample, holds the expected readings in order and compares the readings
// that leave the block against them, field by field.
// ============================================================================
package tcl_checker_pkg;
    import tcl_pkg::*;

    // Index that lies outside the register map; writes to it must be ignored.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int unsigned CODE_COUNT = 154;
    localparam int unsigned THERM_CODES [0:CODE_COUNT-1] = '{
        75, 77, 79, 81, 83, 85, 86, 88, 90, 93,
        95, 97, 99, 101, 103, 105, 108, 110, 112, 114,
        117, 119, 121, 124, 126, 128, 131, 133, 136, 138,
        141, 143, 146, 149, 151, 154, 156, 159, 162, 164,
        167, 170, 173, 175, 178, 181, 184, 186, 189, 192,
        195, 197, 200, 203, 206, 209, 211, 214, 217, 220,
        223, 225, 228, 231, 234, 237, 239, 242, 245, 248,
        251, 253, 256, 259, 261, 264, 267, 270, 272, 275,
        278, 280, 283, 285, 288, 291, 293, 296, 298, 301,
        303, 306, 308, 311, 313, 316, 318, 320, 323, 325,
        327, 330, 332, 334, 336, 339, 341, 343, 345, 347,
        349, 351, 353, 356, 358, 360, 362, 364, 365, 367,
        369, 371, 373, 375, 377, 379, 380, 382, 384, 385,
        387, 389, 390, 392, 394, 395, 397, 398, 400, 401,
        403, 404, 406, 407, 409, 410, 412, 413, 415, 416,
        417, 418, 419, 421
    };

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FAHR_W-1:0]   fahrenheit;
        logic [CELS_W-1:0]   celsius;
    } reading_t;

    class tcl_reading_checker;
        logic [CODE_W-1:0]   open_limit;
        logic [CODE_W-1:0]   short_limit;
        logic [COUNT_W-1:0]  confirm_count;
        logic [COUNT_W-1:0]  fault_run;
        logic [STATUS_W-1:0] status;
        logic [FAHR_W-1:0]   fahrenheit;
        logic [CELS_W-1:0]   celsius;
        reading_t            expected_readings [$];
        int unsigned         mismatches;

        function new();
            open_limit    = 10'd30;
            short_limit   = 10'd500;
            confirm_count = 4'd2;
            fault_run     = '0;
            status        = STATUS_NORMAL;
            fahrenheit    = 8'd36;
            celsius       = '0;
            mismatches    = 0;
        endfunction

        function void flag(string what);
            if (mismatches < 10)
            begin
                $display("%0t: %s", $realtime, what);
            end
            mismatches++;
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_OPEN_LIMIT:    open_limit    = value[CODE_W-1:0];
                REG_SHORT_LIMIT:   short_limit   = value[CODE_W-1:0];
                REG_CONFIRM_COUNT: confirm_count = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void check_register(logic [1:0] idx, logic [31:0] rd);
            logic [31:0] want;
            case (idx)
                REG_OPEN_LIMIT:    want = 32'(open_limit);
                REG_SHORT_LIMIT:   want = 32'(short_limit);
                default:           want = 32'(confirm_count);
            endcase
            if (rd !== want)
            begin
                flag($sformatf("register %0d read back %0d, expected %0d", idx, rd, want));
            end
        endfunction

        // Nearest entry of the ascending table; scanning upwards with <= makes
        // a tie go to the higher index, and codes past either end clamp.
        function int unsigned nearest_entry(int unsigned code);
            int unsigned best;
            int unsigned best_gap;
            int unsigned gap;
            int unsigned i;
            best     = 0;
            best_gap = 32'hFFFF;
            for (i = 0; i < CODE_COUNT; i++)
            begin
                gap = (THERM_CODES[i] > code) ? THERM_CODES[i] - code
                                              : code - THERM_CODES[i];
                if (gap <= best_gap)
                begin
                    best     = i;
                    best_gap = gap;
                end
            end
            return best;
        endfunction

        function logic [CELS_W-1:0] celsius_of(int unsigned f);
            int unsigned steps;
            int unsigned c;
            if (f <= 32)
            begin
                steps = ((32 - f) * 10 + 9) / 18;
                c     = (steps >= 15) ? 0 : 15 - steps;
            end
            else
            begin
                c = ((f - 32) * 10 + 9) / 18 + 15;
            end
            if (c > 127)
            begin
                c = 127;
            end
            return CELS_W'(c);
        endfunction

        function void note_sample(logic [CODE_W-1:0] code, logic hold);
            logic [STATUS_W-1:0] kind;
            int unsigned         f;
            reading_t            r;
            kind = STATUS_NORMAL;
            if (!hold && code < open_limit)
            begin
                kind = STATUS_OPEN;
            end
            else if (!hold && code > short_limit)
            begin
                kind = STATUS_SHORT;
            end

            if (kind != STATUS_NORMAL)
            begin
                // The counter is four bits wide and wraps like the hardware one.
                fault_run = fault_run + 1'b1;
                if (fault_run >= confirm_count)
                begin
                    fault_run  = '0;
                    status     = kind;
                    fahrenheit = '0;
                end
            end
            else
            begin
                f = 5 + nearest_entry(code);
                if (f > 255)
                begin
                    f = 255;
                end
                fault_run  = '0;
                status     = STATUS_NORMAL;
                fahrenheit = FAHR_W'(f);
                celsius    = celsius_of(f);
            end

            r.status     = status;
            r.fahrenheit = fahrenheit;
            r.celsius    = celsius;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic [STATUS_W-1:0] st, logic [FAHR_W-1:0] f,
                                    logic [CELS_W-1:0] c);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                flag($sformatf("unexpected reading: status %0d F %0d C %0d", st, f, c));
            end
            else
            begin
                want = expected_readings.pop_front();
                if (st !== want.status || f !== want.fahrenheit || c !== want.celsius)
                begin
                    flag($sformatf(
                        "reading mismatch: expected st %0d F %0d C %0d, got st %0d F %0d C %0d",
                        want.status, want.fahrenheit, want.celsius, st, f, c));
                end
            end
        endfunction
    endclass

endpackage

FILE: tb/tb_thermistor_channel_linearizer.sv
`timescale 1ns / 100ps
// ============================================================================
// Thermistor channel linearizer testbench
// Drives directed and random thermistor samples through the linearizer under
// several limit and confirm settings, with bursty input and a stalling
// receiver, and checks every reading against an in-bench prediction.
// ============================================================================
module tb_thermistor_channel_linearizer;
    import tcl_pkg::*;
    import tcl_checker_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned LONG_STALL  = 300;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CODE_W-1:0]   adc_code;
    logic                startup_hold;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] sensor_status;
    logic [FAHR_W-1:0]   temp_fahrenheit;
    logic [CELS_W-1:0]   temp_celsius_offset;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    tcl_reading_checker sb;
    int unsigned        burst_left;
    int unsigned        quiet_cycles;
    bit                 long_stall_req;

    thermistor_channel_linearizer u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .adc_code            (adc_code),
        .startup_hold        (startup_hold),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .sensor_status       (sensor_status),
        .temp_fahrenheit     (temp_fahrenheit),
        .temp_celsius_offset (temp_celsius_offset),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Transfer monitor and watchdog. Readings are checked before the sample
    // of the same edge is noted, so that order never matters.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_reading(sensor_status, temp_fahrenheit, temp_celsius_offset);
            end
            if (in_valid && in_ready)
            begin
                sb.note_sample(adc_code, startup_hold);
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver changes its stall pattern after each random span and, when
    // asked, holds off for one long stretch so that the block backs up.
    initial
    begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned i;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_stall_req)
            begin
                repeat (LONG_STALL)
                begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
                long_stall_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            for (i = 0; i < span; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= (i % 3 == 0);
                    default: out_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    task automatic idle_sender(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic offer_sample(input logic [CODE_W-1:0] code, input logic hold);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                idle_sender($urandom_range(1, 20));
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        adc_code     <= code;
        startup_hold <= hold;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Waits until every expected reading has left the block.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // A write followed by a read-back of the same register.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (idx != REG_SPARE)
        begin
            sb.check_register(idx, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] open_lim, input logic [31:0] short_lim,
                             input logic [31:0] confirm);
        write_reg(REG_OPEN_LIMIT, open_lim);
        write_reg(REG_SHORT_LIMIT, short_lim);
        write_reg(REG_CONFIRM_COUNT, confirm);
    endtask

    function automatic logic [CODE_W-1:0] fault_code(input logic want_open);
        logic [CODE_W-1:0] code;
        if (want_open && sb.open_limit != 0)
        begin
            code = CODE_W'($urandom_range(0, sb.open_limit - 1));
        end
        else if (sb.short_limit != 10'd1023)
        begin
            code = CODE_W'($urandom_range(sb.short_limit + 1, 1023));
        end
        else if (sb.open_limit != 0)
        begin
            code = CODE_W'($urandom_range(0, sb.open_limit - 1));
        end
        else
        begin
            code = CODE_W'($urandom_range(0, 1023));
        end
        return code;
    endfunction

    // Mostly in-window samples and runs of faults, up to two longer than the
    // confirm count, mixed with fully random samples.
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned mode;
        int unsigned run_len;
        int unsigned j;
        int unsigned lo;
        int unsigned hi;
        logic        want_open;
        sent = 0;
        while (sent < count)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 4)
            begin
                lo = sb.open_limit;
                hi = sb.short_limit;
                if (lo > hi || $urandom_range(0, 1) == 0)
                begin
                    lo = 60;
                    hi = 440;
                end
                offer_sample(CODE_W'($urandom_range(lo, hi)), $urandom_range(0, 7) == 0);
                sent++;
            end
            else if (mode < 7)
            begin
                run_len   = $urandom_range(1, sb.confirm_count + 2);
                want_open = 1'($urandom_range(0, 1));
                for (j = 0; j < run_len && sent < count; j++)
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        want_open = !want_open;
                    end
                    offer_sample(fault_code(want_open), $urandom_range(0, 15) == 0);
                    sent++;
                end
            end
            else
            begin
                offer_sample(CODE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        adc_code       = '0;
        startup_hold   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        burst_left     = 0;
        quiet_cycles   = 0;
        long_stall_req = 1'b0;
        sb             = new();
        repeat (12)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        // Directed samples under the reset settings: table ends, a tie,
        // window edges, the start-up hold, and open and short confirmation,
        // including a mixed run where the confirming sample decides.
        offer_sample(10'd0, 1'b1);
        offer_sample(10'd1023, 1'b1);
        offer_sample(10'd75, 1'b0);
        offer_sample(10'd421, 1'b0);
        offer_sample(10'd76, 1'b0);
        offer_sample(10'd85, 1'b0);
        offer_sample(10'd86, 1'b0);
        offer_sample(10'd300, 1'b0);
        offer_sample(10'd29, 1'b0);
        offer_sample(10'd29, 1'b0);
        offer_sample(10'd501, 1'b0);
        offer_sample(10'd10, 1'b0);
        offer_sample(10'd600, 1'b0);
        offer_sample(10'd700, 1'b0);
        offer_sample(10'd500, 1'b0);
        offer_sample(10'd30, 1'b0);
        offer_sample(10'd1023, 1'b0);
        offer_sample(10'd0, 1'b0);
        offer_sample(10'd512, 1'b0);
        offer_sample(10'd341, 1'b0);
        offer_sample(10'd682, 1'b1);
        offer_sample(10'd422, 1'b0);
        run_random(200);

        settle();
        configure(32'd0, 32'd1023, 32'd1);
        write_reg(REG_SPARE, 32'h0000_03FF);
        run_random(150);

        settle();
        configure(32'd100, 32'd350, 32'd1);
        long_stall_req = 1'b1;
        run_random(200);

        // Window inverted: unheld samples are faults; open takes priority.
        settle();
        configure(32'd1023, 32'd0, 32'd15);
        run_random(200);

        settle();
        configure(32'd50, 32'd400, 32'd0);
        run_random(150);

        settle();
        configure(32'd200, 32'd800, 32'd15);
        run_random(200);

        settle();
        configure(32'd30, 32'd500, 32'd2);
        run_random(200);

        // Random limits, with random upper bits in the written words.
        settle();
        configure($urandom(), $urandom(), $urandom());
        run_random(250);

        settle();
        repeat (40)
        begin
            @(posedge clk);
        end
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
